// ===== hdl/rbx_pkg.sv =====
package rbx_pkg;

    // Field widths.
    localparam int PosW          = 18;
    localparam int DirW          = 16;
    localparam int OutW          = 26;
    localparam int FracW         = 15;
    localparam int NumLanes      = 3;

    // Divider geometry: the dividend is the face gap magnitude times 2^FracW,
    // padded so that every divider stage retires the same number of bits.
    localparam int StepsPerStage = 4;
    localparam int DivStages     = 9;
    localparam int DvdW          = StepsPerStage * DivStages;
    localparam int MagW          = PosW + 1;
    localparam int QMagW         = MagW + FracW;
    localparam int QW            = QMagW + 1;

    // Pipeline: one prep stage, the divider stages, a min stage, an output stage.
    localparam int MinStage      = DivStages + 1;
    localparam int OutStage      = DivStages + 2;
    localparam int NumStages     = DivStages + 3;

    // Configuration port.
    localparam int CfgAddrW      = 5;
    localparam int CfgDataW      = 32;

    typedef logic signed [PosW-1:0] t_pos;
    typedef logic signed [DirW-1:0] t_dir;
    typedef logic signed [QW-1:0]   t_quot;

    // Register indexes in the configuration map.
    typedef enum logic [2:0] {
        REG_X_LOW  = 3'd0,
        REG_X_HIGH = 3'd1,
        REG_Y_LOW  = 3'd2,
        REG_Y_HIGH = 3'd3,
        REG_Z_LOW  = 3'd4,
        REG_Z_HIGH = 3'd5
    } t_reg_idx;

    localparam t_pos RstXLow  = 18'sd0;
    localparam t_pos RstXHigh = 18'sd16406;
    localparam t_pos RstYLow  = -18'sd7456;
    localparam t_pos RstYHigh = 18'sd7456;
    localparam t_pos RstZLow  = 18'sd0;
    localparam t_pos RstZHigh = 18'sd66355;

    localparam t_quot OutMax = t_quot'(33554431);
    localparam t_quot OutMin = t_quot'(-33554432);

    // One axis as it moves through the divider.
    typedef struct packed {
        logic            nz;
        logic            neg;
        logic [DirW-1:0] den;
        logic [DirW-1:0] rem;
        logic [DvdW-1:0] dvd;
    } t_lane;

    // Pick the face, form the gap magnitude and its sign, and the divisor.
    function automatic t_lane prep(t_pos s, t_pos lo, t_pos hi, t_dir d);
        t_lane                  r;
        logic signed [PosW:0]   diff;
        logic [MagW-1:0]        mag;
        if (d[DirW-1]) begin
            diff = {hi[PosW-1], hi} - {s[PosW-1], s};
        end else begin
            diff = {s[PosW-1], s} - {lo[PosW-1], lo};
        end
        mag   = diff[PosW] ? MagW'(-diff) : MagW'(diff);
        r.nz  = (d != '0);
        r.neg = diff[PosW];
        r.den = d[DirW-1] ? DirW'(-d) : DirW'(d);
        r.rem = '0;
        r.dvd = DvdW'({mag, {FracW{1'b0}}});
        return r;
    endfunction

    // Restoring division, StepsPerStage quotient bits per call.
    function automatic t_lane div_steps(t_lane a);
        t_lane         r;
        logic [DirW:0] trial;
        r = a;
        for (int i = 0; i < StepsPerStage; i++) begin
            trial = {r.rem, r.dvd[DvdW-1]};
            if (trial >= {1'b0, r.den}) begin
                r.rem = DirW'(trial - {1'b0, r.den});
                r.dvd = {r.dvd[DvdW-2:0], 1'b1};
            end else begin
                r.rem = trial[DirW-1:0];
                r.dvd = {r.dvd[DvdW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Signed quotient, truncated toward zero.
    function automatic t_quot signed_quot(t_lane a);
        t_quot q;
        q = t_quot'({1'b0, a.dvd[QMagW-1:0]});
        return a.neg ? -q : q;
    endfunction

endpackage

// ===== hdl/ray_box_backward_exit_distance_top.sv =====
// Throughput: one transaction per cycle without output stalls; each axis has a 36-step
// restoring divider unrolled over nine register stages, four quotient bits per stage.
// Stalls on the output collapse bubbles stage by stage; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the default box faces.
module ray_box_backward_exit_distance_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // start_x[17:0], start_y[35:18], start_z[53:36],
    // dir_x[69:54], dir_y[85:70], dir_z[101:86], zero pad [103:102]
    input  logic [103:0]                        s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // exit_distance[25:0], zero pad [31:26]
    output logic [31:0]                         m_axis_tdata,
    // no_exit[0]
    output logic                                m_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rbx_pkg::CfgAddrW-1:0]        paddr,
    input  logic [rbx_pkg::CfgDataW-1:0]        pwdata,
    output logic [rbx_pkg::CfgDataW-1:0]        prdata,
    output logic                                pready
);

    // Box face registers.
    rbx_pkg::t_pos r_x_low, r_x_high, r_y_low, r_y_high, r_z_low, r_z_high;
    rbx_pkg::t_pos w_wdata;
    rbx_pkg::t_pos w_rdata;
    logic          w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign w_wdata  = rbx_pkg::t_pos'(pwdata[rbx_pkg::PosW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low  <= rbx_pkg::RstXLow;
            r_x_high <= rbx_pkg::RstXHigh;
            r_y_low  <= rbx_pkg::RstYLow;
            r_y_high <= rbx_pkg::RstYHigh;
            r_z_low  <= rbx_pkg::RstZLow;
            r_z_high <= rbx_pkg::RstZHigh;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                rbx_pkg::REG_X_LOW:  r_x_low  <= w_wdata;
                rbx_pkg::REG_X_HIGH: r_x_high <= w_wdata;
                rbx_pkg::REG_Y_LOW:  r_y_low  <= w_wdata;
                rbx_pkg::REG_Y_HIGH: r_y_high <= w_wdata;
                rbx_pkg::REG_Z_LOW:  r_z_low  <= w_wdata;
                rbx_pkg::REG_Z_HIGH: r_z_high <= w_wdata;
                default: ;
            endcase
        end
    end

    // Register readback, sign extended.
    always_comb begin
        unique case (paddr[4:2])
            rbx_pkg::REG_X_LOW:  w_rdata = r_x_low;
            rbx_pkg::REG_X_HIGH: w_rdata = r_x_high;
            rbx_pkg::REG_Y_LOW:  w_rdata = r_y_low;
            rbx_pkg::REG_Y_HIGH: w_rdata = r_y_high;
            rbx_pkg::REG_Z_LOW:  w_rdata = r_z_low;
            rbx_pkg::REG_Z_HIGH: w_rdata = r_z_high;
            default:             w_rdata = '0;
        endcase
    end
    assign prdata = rbx_pkg::CfgDataW'(signed'(w_rdata));

    // Input field unpacking.
    rbx_pkg::t_pos w_sx, w_sy, w_sz;
    rbx_pkg::t_dir w_dx, w_dy, w_dz;
    assign w_sx = rbx_pkg::t_pos'(s_axis_tdata[17:0]);
    assign w_sy = rbx_pkg::t_pos'(s_axis_tdata[35:18]);
    assign w_sz = rbx_pkg::t_pos'(s_axis_tdata[53:36]);
    assign w_dx = rbx_pkg::t_dir'(s_axis_tdata[69:54]);
    assign w_dy = rbx_pkg::t_dir'(s_axis_tdata[85:70]);
    assign w_dz = rbx_pkg::t_dir'(s_axis_tdata[101:86]);

    // Per-stage valid bits and load enables; a stage loads when it is empty
    // or its content moves on.
    logic [rbx_pkg::NumStages-1:0] r_v;
    logic [rbx_pkg::NumStages-1:0] w_ld;

    always_comb begin
        w_ld[rbx_pkg::NumStages-1] = !r_v[rbx_pkg::NumStages-1] || m_axis_tready;
        for (int k = rbx_pkg::NumStages - 2; k >= 0; k--) begin
            w_ld[k] = !r_v[k] || w_ld[k+1];
        end
    end

    assign s_axis_tready = w_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_ld[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < rbx_pkg::NumStages; k++) begin
                if (w_ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Prep stage and divider stages, three axis lanes each.
    rbx_pkg::t_lane r_ln [0:rbx_pkg::DivStages][0:rbx_pkg::NumLanes-1];

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_ln[0][0] <= rbx_pkg::prep(w_sx, r_x_low, r_x_high, w_dx);
            r_ln[0][1] <= rbx_pkg::prep(w_sy, r_y_low, r_y_high, w_dy);
            r_ln[0][2] <= rbx_pkg::prep(w_sz, r_z_low, r_z_high, w_dz);
        end
        for (int k = 1; k <= rbx_pkg::DivStages; k++) begin
            if (w_ld[k]) begin
                for (int i = 0; i < rbx_pkg::NumLanes; i++) begin
                    r_ln[k][i] <= rbx_pkg::div_steps(r_ln[k-1][i]);
                end
            end
        end
    end

    // Min stage: sign the quotients, take the smaller of x and y, and register z alongside.
    rbx_pkg::t_quot w_qx, w_qy, w_best;
    logic           w_any;
    rbx_pkg::t_quot r_best, r_qz;
    logic           r_any, r_nzz;

    always_comb begin
        w_qx   = rbx_pkg::signed_quot(r_ln[rbx_pkg::DivStages][0]);
        w_qy   = rbx_pkg::signed_quot(r_ln[rbx_pkg::DivStages][1]);
        w_best = w_qx;
        w_any  = r_ln[rbx_pkg::DivStages][0].nz;
        if (r_ln[rbx_pkg::DivStages][1].nz && (!w_any || w_qy < w_best)) begin
            w_best = w_qy;
        end
        w_any = w_any | r_ln[rbx_pkg::DivStages][1].nz;
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[rbx_pkg::MinStage]) begin
            r_best <= w_best;
            r_any  <= w_any;
            r_qz   <= rbx_pkg::signed_quot(r_ln[rbx_pkg::DivStages][2]);
            r_nzz  <= r_ln[rbx_pkg::DivStages][2].nz;
        end
    end

    // Output stage: fold in z, then saturate.
    rbx_pkg::t_quot                 w_fin;
    logic                           w_fany;
    logic [rbx_pkg::OutW-1:0]       r_dist;
    logic                           r_no_exit;

    always_comb begin
        w_fin  = r_best;
        w_fany = r_any | r_nzz;
        if (r_nzz && (!r_any || r_qz < r_best)) begin
            w_fin = r_qz;
        end
        priority if (!w_fany || w_fin > rbx_pkg::OutMax) begin
            w_fin = rbx_pkg::OutMax;
        end else if (w_fin < rbx_pkg::OutMin) begin
            w_fin = rbx_pkg::OutMin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[rbx_pkg::OutStage]) begin
            r_dist    <= w_fin[rbx_pkg::OutW-1:0];
            r_no_exit <= !w_fany;
        end
    end

    assign m_axis_tvalid = r_v[rbx_pkg::OutStage];
    assign m_axis_tdata  = 32'(r_dist);
    assign m_axis_tuser  = r_no_exit;

    // A result without any nonzero component carries the upper limit.
    a_no_exit_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[25:0] == 26'h1ffffff)
        else $error("no_exit result without saturated distance");

    // An empty output stage never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage empty");

    // The x and z divider remainders stay below the divisor.
    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[rbx_pkg::DivStages] && r_ln[rbx_pkg::DivStages][0].nz
        |-> r_ln[rbx_pkg::DivStages][0].rem < r_ln[rbx_pkg::DivStages][0].den)
        else $error("x divider remainder out of range");

    a_rem_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[rbx_pkg::DivStages] && r_ln[rbx_pkg::DivStages][2].nz
        |-> r_ln[rbx_pkg::DivStages][2].rem < r_ln[rbx_pkg::DivStages][2].den)
        else $error("z divider remainder out of range");

endmodule

// ===== test/ray_box_backward_exit_distance_top_test.sv =====
module ray_box_backward_exit_distance_top_test;

    localparam longint DistMax = 64'sd33554431;
    localparam longint DistMin = -64'sd33554432;
    localparam int WatchLimit = 20000;
    localparam int NumDirected = 16;

    logic i_clk;
    logic i_rst_n;
    logic [103:0] s_axis_tdata;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [31:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic psel;
    logic penable;
    logic pwrite;
    logic [rbx_pkg::CfgAddrW-1:0] paddr;
    logic [rbx_pkg::CfgDataW-1:0] pwdata;
    logic [rbx_pkg::CfgDataW-1:0] prdata;
    logic pready;

    typedef struct packed {
        rbx_pkg::t_pos sx;
        rbx_pkg::t_pos sy;
        rbx_pkg::t_pos sz;
        rbx_pkg::t_dir dx;
        rbx_pkg::t_dir dy;
        rbx_pkg::t_dir dz;
    } t_track;

    typedef struct packed {
        logic [rbx_pkg::OutW-1:0] exit_dist;
        logic no_exit;
    } t_exit;

    // One row of the directed table; a known result is given where it is obvious.
    typedef struct {
        t_track trk;
        bit known;
        t_exit res;
    } t_row;

    rbx_pkg::t_pos box_face[6];
    t_exit exit_queue[$];
    bit failed;
    int idle_cycles;
    int stall_pct;
    int send_pct;
    t_row rows[NumDirected];

    ray_box_backward_exit_distance_top uut (.*);

    always #5 i_clk = ~i_clk;

    // Distance to one face along the reversed direction, truncated toward zero.
    function automatic void slab_quot(rbx_pkg::t_pos s, rbx_pkg::t_dir d,
                                      rbx_pkg::t_pos lo, rbx_pkg::t_pos hi,
                                      inout longint best, inout bit any);
        longint num;
        longint den;
        longint q;
        if (d == 0) return;
        if (d < 0) begin
            num = (longint'(hi) - longint'(s)) * 32768;
            den = -longint'(d);
        end else begin
            num = (longint'(s) - longint'(lo)) * 32768;
            den = longint'(d);
        end
        q = num / den;
        if (!any || q < best) best = q;
        any = 1;
    endfunction

    function automatic t_exit exit_distance(t_track t);
        longint best;
        bit any;
        t_exit r;
        best = DistMax;
        any = 0;
        slab_quot(t.sx, t.dx, box_face[rbx_pkg::REG_X_LOW], box_face[rbx_pkg::REG_X_HIGH],
                  best, any);
        slab_quot(t.sy, t.dy, box_face[rbx_pkg::REG_Y_LOW], box_face[rbx_pkg::REG_Y_HIGH],
                  best, any);
        slab_quot(t.sz, t.dz, box_face[rbx_pkg::REG_Z_LOW], box_face[rbx_pkg::REG_Z_HIGH],
                  best, any);
        if (!any) best = DistMax;
        if (best > DistMax) best = DistMax;
        if (best < DistMin) best = DistMin;
        r.exit_dist = best[rbx_pkg::OutW-1:0];
        r.no_exit = !any;
        return r;
    endfunction

    function automatic logic [103:0] pack_track(t_track t);
        return {2'b00, t.dz, t.dy, t.dx, t.sz, t.sy, t.sx};
    endfunction

    function automatic t_track make_track(int sx, int sy, int sz, int dx, int dy, int dz);
        t_track t;
        t.sx = rbx_pkg::t_pos'(sx); t.sy = rbx_pkg::t_pos'(sy); t.sz = rbx_pkg::t_pos'(sz);
        t.dx = rbx_pkg::t_dir'(dx); t.dy = rbx_pkg::t_dir'(dy); t.dz = rbx_pkg::t_dir'(dz);
        return t;
    endfunction

    function automatic rbx_pkg::t_dir rand_dir();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return rbx_pkg::t_dir'(-32768);
            2: return rbx_pkg::t_dir'(32767);
            3: return rbx_pkg::t_dir'(int'($urandom_range(1, 16)) *
                                      ($urandom_range(0, 1) ? -1 : 1));
            default: return rbx_pkg::t_dir'($urandom);
        endcase
    endfunction

    function automatic rbx_pkg::t_pos rand_pos();
        case ($urandom_range(0, 5))
            0: return rbx_pkg::t_pos'(-131072);
            1: return rbx_pkg::t_pos'(131071);
            2: return rbx_pkg::t_pos'($urandom);
            default: return rbx_pkg::t_pos'($urandom_range(0, 70000)) - rbx_pkg::t_pos'(8000);
        endcase
    endfunction

    // Register write with a setup and an access phase.
    task automatic write_face(rbx_pkg::t_reg_idx idx, rbx_pkg::t_pos val);
        @(negedge i_clk);
        psel = 1; penable = 0; pwrite = 1;
        paddr = rbx_pkg::CfgAddrW'(4 * int'(idx));
        pwdata = rbx_pkg::CfgDataW'(signed'(val));
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        box_face[idx] = val;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic wait_drained();
        while (exit_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Offer one track transaction and hold it until it is taken.
    task automatic send_track(t_track t);
        while ($urandom_range(0, 99) < send_pct) @(negedge i_clk);
        s_axis_tdata = pack_track(t);
        s_axis_tvalid = 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        exit_queue.push_back(exit_distance(t));
        @(negedge i_clk);
        s_axis_tvalid = 0;
    endtask

    task automatic send_random(int n);
        t_track t;
        for (int i = 0; i < n; i++) begin
            t.sx = rand_pos(); t.sy = rand_pos(); t.sz = rand_pos();
            t.dx = rand_dir(); t.dy = rand_dir(); t.dz = rand_dir();
            send_track(t);
        end
    endtask

    // Result side: random stalls and comparison against the oldest expectation.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_exit want;
        if (i_rst_n && ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (exit_queue.size() == 0) begin
                $display("%0t: unexpected result transaction exit_distance=%0d no_exit=%0b",
                         $time, $signed(m_axis_tdata[rbx_pkg::OutW-1:0]), m_axis_tuser);
                failed = 1;
            end else begin
                want = exit_queue.pop_front();
                if (m_axis_tdata[rbx_pkg::OutW-1:0] !== want.exit_dist) begin
                    $display("%0t: exit_distance expected %0d actual %0d", $time,
                             $signed(want.exit_dist), $signed(m_axis_tdata[rbx_pkg::OutW-1:0]));
                    failed = 1;
                end
                if (m_axis_tuser !== want.no_exit) begin
                    $display("%0t: no_exit expected %0b actual %0b", $time,
                             want.no_exit, m_axis_tuser);
                    failed = 1;
                end
                if (m_axis_tdata[31:rbx_pkg::OutW] !== '0) begin
                    $display("%0t: pad expected 0 actual %0h", $time,
                             m_axis_tdata[31:rbx_pkg::OutW]);
                    failed = 1;
                end
            end
        end
        if (idle_cycles > WatchLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_clk = 0; i_rst_n = 0;
        s_axis_tdata = '0; s_axis_tvalid = 0; m_axis_tready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        failed = 0; idle_cycles = 0; stall_pct = 38; send_pct = 38;
        box_face[rbx_pkg::REG_X_LOW] = rbx_pkg::RstXLow;
        box_face[rbx_pkg::REG_X_HIGH] = rbx_pkg::RstXHigh;
        box_face[rbx_pkg::REG_Y_LOW] = rbx_pkg::RstYLow;
        box_face[rbx_pkg::REG_Y_HIGH] = rbx_pkg::RstYHigh;
        box_face[rbx_pkg::REG_Z_LOW] = rbx_pkg::RstZLow;
        box_face[rbx_pkg::REG_Z_HIGH] = rbx_pkg::RstZHigh;

        // Directed rows with the default box; a few results follow directly.
        rows[0] = '{make_track(0, 0, 0, 0, 0, 0), 1, '{26'h1ffffff, 1'b1}};
        rows[1] = '{make_track(1000, 0, 0, -32768, 0, 0), 1, '{26'(15406), 1'b0}};
        rows[2] = '{make_track(1000, 0, 0, 32767, 0, 0), 0, '{0, 0}};
        rows[3] = '{make_track(0, 0, 0, 0, 0, -32768), 1, '{26'(66355), 1'b0}};
        rows[4] = '{make_track(0, 7456, 0, 0, 32767, 0), 0, '{0, 0}};
        rows[5] = '{make_track(-131072, 0, 0, -1, 0, 0), 1, '{26'h1ffffff, 1'b0}};
        rows[6] = '{make_track(131071, 0, 0, -1, 0, 0), 1, '{26'h2000000, 1'b0}};
        rows[7] = '{make_track(131071, 131071, 131071, 1, 1, 1), 1, '{26'h1ffffff, 1'b0}};
        rows[8] = '{make_track(-131072, -131072, -131072, 1, 1, 1), 1, '{26'h2000000, 1'b0}};
        rows[9] = '{make_track(500, 200, 300, 100, -200, 30000), 0, '{0, 0}};
        rows[10] = '{make_track(20000, 0, 0, -32768, 0, 0), 0, '{0, 0}};
        rows[11] = '{make_track(5000, -3000, 40000, -16384, 16384, -23170), 0, '{0, 0}};
        rows[12] = '{make_track(0, 0, 0, 32767, 32767, 32767), 1, '{26'(0), 1'b0}};
        rows[13] = '{make_track(-1, -1, -1, -32768, -32768, -32768), 0, '{0, 0}};
        rows[14] = '{make_track(100, 100, 100, 0, 0, 5), 0, '{0, 0}};
        rows[15] = '{make_track(-200, 9000, 70000, 32767, -32768, 1), 0, '{0, 0}};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        for (int i = 0; i < NumDirected; i++) begin
            send_track(rows[i].trk);
            if (rows[i].known && exit_queue[$] !== rows[i].res) begin
                $display("%0t: row %0d expected %0h actual prediction %0h", $time, i,
                         rows[i].res, exit_queue[$]);
                failed = 1;
            end
        end
        send_random(150);

        // Hold off until the pipeline is empty, then walk through box settings.
        wait_drained();
        for (int phase = 0; phase < 6; phase++) begin
            for (int r = 0; r < 6; r++) begin
                case (phase)
                    0: write_face(rbx_pkg::t_reg_idx'(r),
                                  (r % 2) ? rbx_pkg::t_pos'(131071) : rbx_pkg::t_pos'(-131072));
                    1: write_face(rbx_pkg::t_reg_idx'(r),
                                  (r % 2) ? rbx_pkg::t_pos'(-131072) : rbx_pkg::t_pos'(131071));
                    2: write_face(rbx_pkg::t_reg_idx'(r), rbx_pkg::t_pos'(0));
                    default: write_face(rbx_pkg::t_reg_idx'(r), rand_pos());
                endcase
            end
            if (phase == 3) begin
                stall_pct = 0; send_pct = 0;
            end else begin
                stall_pct = 38; send_pct = 38;
            end
            send_random(180);
            wait_drained();
        end

        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
